// ===== rtl/core/tsq_pkg.sv =====
package tsq_pkg;

    // Field widths of the beats
    localparam int MODE_W   = 2;
    localparam int FLAGS_W  = 16;
    localparam int STATE_W  = 3;
    localparam int SLOT_W   = 2;
    localparam int FSEL_W   = 4;
    localparam int ACT_W    = 2;
    localparam int CODE_W   = 3;

    // Default sizes
    localparam int DEF_NUM_STATES      = 8;
    localparam int DEF_STEPS_PER_STATE = 4;
    localparam int DEF_NUM_FLAGS       = 16;

    // Item modes
    localparam logic [MODE_W-1:0] MODE_TICK    = 2'd0;
    localparam logic [MODE_W-1:0] MODE_WR_STEP = 2'd1;
    localparam logic [MODE_W-1:0] MODE_WR_ATTR = 2'd2;
    localparam logic [MODE_W-1:0] MODE_START   = 2'd3;

    // Sub-step actions; any other code ends the walk
    localparam logic [ACT_W-1:0] ACT_NEXT = 2'd0;
    localparam logic [ACT_W-1:0] ACT_JUMP = 2'd1;
    localparam logic [ACT_W-1:0] ACT_END  = 2'd2;

    typedef struct packed {
        logic [MODE_W-1:0]  mode;
        logic [FLAGS_W-1:0] flags;
        logic [STATE_W-1:0] state_sel;
        logic [SLOT_W-1:0]  slot_sel;
        logic [FSEL_W-1:0]  flag_sel;
        logic [ACT_W-1:0]   on_true;
        logic [ACT_W-1:0]   on_false;
        logic [STATE_W-1:0] target;
        logic               has_pass;
        logic               has_entry;
        logic               has_exit;
        logic [CODE_W-1:0]  report_code;
    } in_beat_t;

    typedef struct packed {
        logic               pass_fired;
        logic               exit_fired;
        logic               entry_fired;
        logic               jumped;
        logic [STATE_W-1:0] state_index_now;
        logic [CODE_W-1:0]  reported_state;
        logic               running;
        logic               fault;
    } out_beat_t;

    typedef struct packed {
        logic [FSEL_W-1:0]  flag_sel;
        logic [ACT_W-1:0]   on_true;
        logic [ACT_W-1:0]   on_false;
        logic [STATE_W-1:0] target;
    } step_entry_t;

    typedef struct packed {
        logic              has_pass;
        logic              has_entry;
        logic              has_exit;
        logic [CODE_W-1:0] report_code;
    } attr_t;

    // Decision of one sub-step
    typedef struct packed {
        logic               is_next;
        logic               is_jump;
        logic [STATE_W-1:0] target;
    } step_dec_t;

endpackage

// ===== rtl/core/tsq_ram.sv =====
module tsq_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 8
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ===== rtl/core/tsq_step_eval.sv =====
module tsq_step_eval #(
    parameter int NUM_FLAGS = tsq_pkg::DEF_NUM_FLAGS
) (
    input  tsq_pkg::step_entry_t             entry,
    input  logic [tsq_pkg::FLAGS_W-1:0]      flags,
    output tsq_pkg::step_dec_t               dec
);
    import tsq_pkg::*;

    logic             flag_val;
    logic [ACT_W-1:0] act;

    // Flags past the configured count read as zero
    assign flag_val = (32'(entry.flag_sel) < 32'(NUM_FLAGS)) && flags[entry.flag_sel];
    assign act      = flag_val ? entry.on_true : entry.on_false;

    assign dec.is_next = (act == ACT_NEXT);
    assign dec.is_jump = (act == ACT_JUMP);
    assign dec.target  = entry.target;

endmodule

// ===== rtl/core/table_driven_state_sequencer.sv =====
// Flow: a table write, a start, a stopped tick or a tick that faults in an unloaded state
// goes from S_IDLE straight to S_DONE, which loads the result beat; a running tick walks its
// sub-steps (1..STEPS_PER_STATE, one table read each) in S_STEP, then S_TGT on a jump, then S_DONE.
// One item at a time: the next beat is taken only once the result register has loaded, and
// a held result keeps the block waiting in S_DONE.
// Reset: control, current/published state and loaded bits clear; tables undefined.
module table_driven_state_sequencer #(
    parameter int NUM_STATES      = tsq_pkg::DEF_NUM_STATES,
    parameter int STEPS_PER_STATE = tsq_pkg::DEF_STEPS_PER_STATE,
    parameter int NUM_FLAGS       = tsq_pkg::DEF_NUM_FLAGS
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  tsq_pkg::in_beat_t  s_data,
    output logic               m_valid,
    input  logic               m_ready,
    output tsq_pkg::out_beat_t m_data
);
    import tsq_pkg::*;

    localparam int STEP_DEPTH = NUM_STATES * STEPS_PER_STATE;
    localparam int AW         = $clog2(STEP_DEPTH);
    localparam int SW         = $clog2(NUM_STATES);
    localparam int KW         = (STEPS_PER_STATE > 1) ? $clog2(STEPS_PER_STATE) : 1;
    localparam int STEP_W     = $bits(step_entry_t);
    localparam int ATTR_W     = $bits(attr_t);

    // Sequencer codes
    localparam logic [1:0] S_IDLE = 2'd0;  // take a beat
    localparam logic [1:0] S_STEP = 2'd1;  // test one sub-step per cycle
    localparam logic [1:0] S_TGT  = 2'd2;  // target attributes arrive
    localparam logic [1:0] S_DONE = 2'd3;  // load result register

    function automatic logic [SW-1:0] st_idx(input logic [STATE_W-1:0] s);
        logic [31:0] w;
        w = 32'(s);
        return w[SW-1:0];
    endfunction

    function automatic logic [AW-1:0] step_addr(input logic [STATE_W-1:0] s,
                                                input logic [31:0] k);
        logic [31:0] a;
        a = 32'(s) * 32'(STEPS_PER_STATE) + k;
        return a[AW-1:0];
    endfunction

    logic [1:0]            fsm_reg, fsm_next;
    logic                  run_reg, run_next;
    logic [STATE_W-1:0]    cur_reg, cur_next;
    logic [CODE_W-1:0]     pub_reg, pub_next;
    logic [NUM_STATES-1:0] loaded_reg, loaded_next;
    logic [KW-1:0]         k_reg, k_next;
    logic [STATE_W-1:0]    tgt_reg, tgt_next;
    logic [FLAGS_W-1:0]    flags_reg, flags_next;
    logic                  pass_reg, pass_next;
    logic                  exit_reg, exit_next;
    logic                  entry_reg, entry_next;
    logic                  jump_reg, jump_next;
    logic                  fault_reg, fault_next;
    logic                  m_valid_reg, m_valid_next;
    out_beat_t             m_data_reg, m_data_next;

    logic        accept;
    logic        cur_ok;
    logic        tgt_ok;
    logic        last_slot;
    logic        step_we;
    logic        attr_we;
    logic        jump_now;
    logic [AW-1:0] step_raddr;
    logic [SW-1:0] attr_raddr;
    logic [STEP_W-1:0] step_rbits;
    logic [ATTR_W-1:0] attr_rbits;
    step_entry_t step_rd;
    attr_t       attr_rd;
    step_entry_t step_wd;
    attr_t       attr_wd;
    step_dec_t   dec;

    assign s_ready = (fsm_reg == S_IDLE);
    assign accept  = s_valid && s_ready;
    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    // A state is usable once its attributes were written
    assign cur_ok = (32'(cur_reg) < 32'(NUM_STATES)) && loaded_reg[st_idx(cur_reg)];
    assign tgt_ok = (32'(dec.target) < 32'(NUM_STATES)) && loaded_reg[st_idx(dec.target)];
    assign last_slot = (32'(k_reg) == 32'(STEPS_PER_STATE - 1));
    assign jump_now  = (fsm_reg == S_STEP) && dec.is_jump && tgt_ok;

    // Table writes, dropped when out of range
    assign step_we = accept && (s_data.mode == MODE_WR_STEP)
                     && (32'(s_data.state_sel) < 32'(NUM_STATES))
                     && (32'(s_data.slot_sel) < 32'(STEPS_PER_STATE));
    assign attr_we = accept && (s_data.mode == MODE_WR_ATTR)
                     && (32'(s_data.state_sel) < 32'(NUM_STATES));

    assign step_wd.flag_sel = s_data.flag_sel;
    assign step_wd.on_true  = s_data.on_true;
    assign step_wd.on_false = s_data.on_false;
    assign step_wd.target   = s_data.target;
    assign attr_wd.has_pass    = s_data.has_pass;
    assign attr_wd.has_entry   = s_data.has_entry;
    assign attr_wd.has_exit    = s_data.has_exit;
    assign attr_wd.report_code = s_data.report_code;

    // Read address: slot 0 on a tick, the following slot while advancing
    always_comb begin
        if (fsm_reg == S_STEP && !last_slot) begin
            step_raddr = step_addr(cur_reg, 32'(k_reg) + 32'd1);
        end else if (fsm_reg == S_STEP) begin
            step_raddr = step_addr(cur_reg, 32'(k_reg));
        end else begin
            step_raddr = step_addr(cur_reg, 32'd0);
        end
    end

    // Attribute port: current state, switch to the target on a jump
    assign attr_raddr = jump_now ? st_idx(dec.target) :
                        (fsm_reg == S_TGT) ? st_idx(tgt_reg) : st_idx(cur_reg);

    tsq_ram #(
        .WIDTH (STEP_W),
        .DEPTH (STEP_DEPTH)
    ) u_step_ram (
        .aclk  (aclk),
        .we    (step_we),
        .waddr (step_addr(s_data.state_sel, 32'(s_data.slot_sel))),
        .wdata (step_wd),
        .raddr (step_raddr),
        .rdata (step_rbits)
    );

    tsq_ram #(
        .WIDTH (ATTR_W),
        .DEPTH (NUM_STATES)
    ) u_attr_ram (
        .aclk  (aclk),
        .we    (attr_we),
        .waddr (st_idx(s_data.state_sel)),
        .wdata (attr_wd),
        .raddr (attr_raddr),
        .rdata (attr_rbits)
    );

    assign step_rd = step_rbits;
    assign attr_rd = attr_rbits;

    // Shared sub-step tester
    tsq_step_eval #(
        .NUM_FLAGS (NUM_FLAGS)
    ) u_eval (
        .entry (step_rd),
        .flags (flags_reg),
        .dec   (dec)
    );

    always_comb begin
        fsm_next     = fsm_reg;
        run_next     = run_reg;
        cur_next     = cur_reg;
        pub_next     = pub_reg;
        loaded_next  = loaded_reg;
        k_next       = k_reg;
        tgt_next     = tgt_reg;
        flags_next   = flags_reg;
        pass_next    = pass_reg;
        exit_next    = exit_reg;
        entry_next   = entry_reg;
        jump_next    = jump_reg;
        fault_next   = fault_reg;
        m_valid_next = m_valid_reg;
        m_data_next  = m_data_reg;

        // Drop the result beat once taken
        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end

        unique case (fsm_reg)
            S_IDLE: begin
                if (accept) begin
                    flags_next = s_data.flags;
                    pass_next  = 1'b0;
                    exit_next  = 1'b0;
                    entry_next = 1'b0;
                    jump_next  = 1'b0;
                    fault_next = 1'b0;
                    k_next     = '0;
                    fsm_next   = S_DONE;
                    unique case (s_data.mode)
                        MODE_TICK: begin
                            if (run_reg && !cur_ok) begin
                                fault_next = 1'b1;
                                run_next   = 1'b0;
                            end else if (run_reg) begin
                                fsm_next = S_STEP;
                            end
                        end
                        MODE_WR_ATTR: begin
                            if (attr_we) begin
                                loaded_next[st_idx(s_data.state_sel)] = 1'b1;
                            end
                        end
                        MODE_START: begin
                            run_next = 1'b1;
                        end
                        default: begin
                        end
                    endcase
                end
            end
            S_STEP: begin
                // Attribute port holds the current state here
                pass_next = attr_rd.has_pass;
                if (dec.is_jump && !tgt_ok) begin
                    fault_next = 1'b1;
                    run_next   = 1'b0;
                    fsm_next   = S_DONE;
                end else if (dec.is_jump) begin
                    exit_next = attr_rd.has_exit;
                    tgt_next  = dec.target;
                    fsm_next  = S_TGT;
                end else if (dec.is_next && !last_slot) begin
                    k_next = k_reg + KW'(1);
                end else begin
                    // end action, unknown code, or ran off the last slot
                    fsm_next = S_DONE;
                end
            end
            S_TGT: begin
                cur_next   = tgt_reg;
                entry_next = attr_rd.has_entry;
                jump_next  = 1'b1;
                if (attr_rd.report_code != '0) begin
                    pub_next = attr_rd.report_code;
                end
                fsm_next = S_DONE;
            end
            S_DONE: begin
                // Hold until the output register is free
                if (!m_valid_reg || m_ready) begin
                    m_valid_next                = 1'b1;
                    m_data_next.pass_fired      = pass_reg;
                    m_data_next.exit_fired      = exit_reg;
                    m_data_next.entry_fired     = entry_reg;
                    m_data_next.jumped          = jump_reg;
                    m_data_next.state_index_now = cur_reg;
                    m_data_next.reported_state  = pub_reg;
                    m_data_next.running         = run_reg;
                    m_data_next.fault           = fault_reg;
                    fsm_next                    = S_IDLE;
                end
            end
            default: begin
                fsm_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fsm_reg     <= S_IDLE;
            run_reg     <= 1'b0;
            cur_reg     <= '0;
            pub_reg     <= '0;
            loaded_reg  <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            fsm_reg     <= fsm_next;
            run_reg     <= run_next;
            cur_reg     <= cur_next;
            pub_reg     <= pub_next;
            loaded_reg  <= loaded_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        k_reg      <= k_next;
        tgt_reg    <= tgt_next;
        flags_reg  <= flags_next;
        pass_reg   <= pass_next;
        exit_reg   <= exit_next;
        entry_reg  <= entry_next;
        jump_reg   <= jump_next;
        fault_reg  <= fault_next;
        m_data_reg <= m_data_next;
    end

`ifndef ASSERT_OFF
    // A fault stops the machine in the same beat
    a_fault_stops: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg && m_data_reg.fault |-> !m_data_reg.running)
        else $error("fault beat reports running");

    // Exit and entry fire only with a taken jump, never with a fault
    a_jump_actions: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg && (m_data_reg.exit_fired || m_data_reg.entry_fired || m_data_reg.fault)
        |-> (m_data_reg.jumped != m_data_reg.fault))
        else $error("exit/entry without jump, or jump with fault");

    // A running tick in a loaded state starts the sub-step walk
    a_tick_walks: assert property (@(posedge aclk) disable iff (!aresetn)
        accept && (s_data.mode == MODE_TICK) && run_reg && cur_ok |=> fsm_reg == S_STEP)
        else $error("running tick did not walk its sub-steps");

    // A jump moves the current state to the captured target
    a_tgt_update: assert property (@(posedge aclk) disable iff (!aresetn)
        fsm_reg == S_TGT |=> (cur_reg == $past(tgt_reg)) && jump_reg)
        else $error("jump did not update current state");
`endif

endmodule

// ===== tb/tb.sv =====
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import tsq_pkg::*;

    // Sizes match the defaults the block is built with here
    localparam int NUM_ST = DEF_NUM_STATES;
    localparam int SLOTS  = DEF_STEPS_PER_STATE;

    // Action code 3 is not named in the package; the block must treat it as an end
    localparam logic [ACT_W-1:0] ACT_SPARE = 2'd3;

    // State indexes used by the directed table
    localparam logic [STATE_W-1:0] HOME = 3'd0;
    localparam logic [STATE_W-1:0] WORK = 3'd1;
    localparam logic [STATE_W-1:0] VOID = 3'd7;

    localparam int CYCLE_LIMIT   = 200_000;
    localparam int HOLD_CYCLES   = 80;
    localparam int RANDOM_ITEMS  = 760;
    localparam int CLOSING_ITEMS = 40;
    localparam int SETTLE_CYCLES = 16;

    logic       aclk = 1'b0;
    logic       aresetn;
    logic       s_valid;
    logic       s_ready;
    in_beat_t   s_data;
    logic       m_valid;
    logic       m_ready = 1'b0;
    out_beat_t  m_data;

    // Mirror of the sequencer: table contents, loaded states, position and run state
    step_entry_t          step_tab [NUM_ST*SLOTS];
    attr_t                attr_tab [NUM_ST];
    bit [NUM_ST-1:0]      state_loaded = '0;
    bit [NUM_ST*SLOTS-1:0] slot_written = '0;
    logic [STATE_W-1:0]   cur_state = '0;
    logic [CODE_W-1:0]    pub_code  = '0;
    bit                   run_on    = 1'b0;

    // Outcomes of accepted beats, oldest first
    out_beat_t outcome_fifo [$];

    bit          idle_on     = 1'b1;
    bit          hold_go     = 1'b0;
    logic        hold_active = 1'b0;
    int          ready_gap   = 0;
    int unsigned cycle_count = 0;
    int unsigned mismatch_count = 0;
    int unsigned items_sent     = 0;
    int unsigned beats_checked  = 0;
    int unsigned jumps_seen     = 0;
    int unsigned faults_seen    = 0;

    table_driven_state_sequencer dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    always #5 aclk = ~aclk;

    // Advance the mirror by one beat and return the result beat it must produce.
    // Table writes, starts and stopped ticks only report position and run state.
    function automatic out_beat_t sequence_item(input in_beat_t it);
        out_beat_t        res;
        step_entry_t      ent;
        logic [ACT_W-1:0] act;
        int               idx;
        res = '0;
        case (it.mode)
            MODE_WR_STEP: begin
                idx = int'(it.state_sel) * SLOTS + int'(it.slot_sel);
                step_tab[idx].flag_sel = it.flag_sel;
                step_tab[idx].on_true  = it.on_true;
                step_tab[idx].on_false = it.on_false;
                step_tab[idx].target   = it.target;
                slot_written[idx]      = 1'b1;
            end
            MODE_WR_ATTR: begin
                attr_tab[it.state_sel].has_pass    = it.has_pass;
                attr_tab[it.state_sel].has_entry   = it.has_entry;
                attr_tab[it.state_sel].has_exit    = it.has_exit;
                attr_tab[it.state_sel].report_code = it.report_code;
                state_loaded[it.state_sel]         = 1'b1;
            end
            MODE_START: run_on = 1'b1;
            MODE_TICK: begin
                if (run_on && !state_loaded[cur_state]) begin
                    // sitting in a state that was never loaded: stop with a fault
                    res.fault = 1'b1;
                    run_on    = 1'b0;
                end else if (run_on) begin
                    res.pass_fired = attr_tab[cur_state].has_pass;
                    for (int k = 0; k < SLOTS; k++) begin
                        ent = step_tab[int'(cur_state) * SLOTS + k];
                        act = it.flags[ent.flag_sel] ? ent.on_true : ent.on_false;
                        if (act == ACT_NEXT) continue;
                        if (act == ACT_JUMP) begin
                            if (!state_loaded[ent.target]) begin
                                // jump into an unloaded state is refused
                                res.fault = 1'b1;
                                run_on    = 1'b0;
                            end else begin
                                res.exit_fired = attr_tab[cur_state].has_exit;
                                cur_state      = ent.target;
                                if (attr_tab[cur_state].report_code != '0)
                                    pub_code = attr_tab[cur_state].report_code;
                                res.entry_fired = attr_tab[cur_state].has_entry;
                                res.jumped      = 1'b1;
                            end
                        end
                        // end, spare code or a jump: stop the walk
                        break;
                    end
                end
            end
        endcase
        res.state_index_now = cur_state;
        res.reported_state  = pub_code;
        res.running         = run_on;
        return res;
    endfunction

    // Fill every field with random bits; callers then set what matters
    function automatic in_beat_t junk_item();
        logic [63:0] raw;
        raw = {$urandom, $urandom};
        return raw[$bits(in_beat_t)-1:0];
    endfunction

    function automatic in_beat_t step_write(input logic [STATE_W-1:0] st,
                                            input logic [SLOT_W-1:0]  slot,
                                            input logic [FSEL_W-1:0]  fsel,
                                            input logic [ACT_W-1:0]   t_act,
                                            input logic [ACT_W-1:0]   f_act,
                                            input logic [STATE_W-1:0] tgt);
        in_beat_t it;
        it           = junk_item();
        it.mode      = MODE_WR_STEP;
        it.state_sel = st;
        it.slot_sel  = slot;
        it.flag_sel  = fsel;
        it.on_true   = t_act;
        it.on_false  = f_act;
        it.target    = tgt;
        return it;
    endfunction

    function automatic in_beat_t attr_write(input logic [STATE_W-1:0] st,
                                            input logic pass, input logic entry,
                                            input logic leave,
                                            input logic [CODE_W-1:0] code);
        in_beat_t it;
        it             = junk_item();
        it.mode        = MODE_WR_ATTR;
        it.state_sel   = st;
        it.has_pass    = pass;
        it.has_entry   = entry;
        it.has_exit    = leave;
        it.report_code = code;
        return it;
    endfunction

    function automatic in_beat_t tick_item(input logic [FLAGS_W-1:0] flags);
        in_beat_t it;
        it       = junk_item();
        it.mode  = MODE_TICK;
        it.flags = flags;
        return it;
    endfunction

    function automatic in_beat_t start_item();
        in_beat_t it;
        it      = junk_item();
        it.mode = MODE_START;
        return it;
    endfunction

    // Pick a beat that keeps the table sane: a state is only loaded once all of
    // its slots hold a written sub-step, so no tick ever reads an unwritten slot.
    function automatic in_beat_t random_item();
        in_beat_t           it;
        int unsigned        r;
        logic [STATE_W-1:0] t;
        it = junk_item();
        r  = $urandom_range(0, 99);
        if (!run_on && r < 60) begin
            it.mode = MODE_START;
        end else if (r < 72) begin
            it.mode = MODE_TICK;
            case ($urandom_range(0, 7))
                0:       it.flags = '0;
                1:       it.flags = '1;
                default: it.flags = FLAGS_W'($urandom);
            endcase
        end else if (r < 86) begin
            it.mode = MODE_WR_STEP;
            // steer most jump targets at loaded states so runs last longer
            if ($urandom_range(0, 3) != 0) begin
                do t = STATE_W'($urandom_range(0, NUM_ST - 1)); while (!state_loaded[t]);
                it.target = t;
            end
        end else if (r < 94) begin
            it.mode = MODE_WR_ATTR;
            if (!(&slot_written[int'(it.state_sel) * SLOTS +: SLOTS])) begin
                // fill a missing slot of this state first
                it.mode = MODE_WR_STEP;
                for (int k = 0; k < SLOTS; k++) begin
                    if (!slot_written[int'(it.state_sel) * SLOTS + k]) begin
                        it.slot_sel = SLOT_W'(k);
                        break;
                    end
                end
            end
        end else begin
            it.mode = MODE_START;
        end
        return it;
    endfunction

    // Offer one beat, hold it until taken, then record what it must produce.
    // Valid stays high after the handshake so back-to-back beats need no toggle.
    task automatic offer_item(input in_beat_t item);
        if (idle_on && $urandom_range(0, 4) == 0) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 11)) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= item;
        do @(posedge aclk); while (s_ready !== 1'b1);
        outcome_fifo.push_back(sequence_item(item));
        items_sent++;
    endtask

    function automatic void compare_field(input string name, input logic [7:0] want,
                                          input logic [7:0] got);
        if (got !== want) begin
            $display("%0t: %s expected %0d, got %0d", $time, name, want, got);
            mismatch_count++;
        end
    endfunction

    // Take result beats, check each against the oldest outcome, and drive
    // m_ready: a long hold when asked, else random stall bursts while idling.
    always @(posedge aclk) begin : result_check
        out_beat_t want;
        if (aresetn === 1'b1 && m_valid === 1'b1 && m_ready === 1'b1) begin
            beats_checked++;
            if (outcome_fifo.size() == 0) begin
                $display("%0t: result beat %h arrived with no outcome pending",
                         $time, m_data);
                mismatch_count++;
            end else begin
                want = outcome_fifo.pop_front();
                compare_field("pass_fired", 8'(want.pass_fired), 8'(m_data.pass_fired));
                compare_field("exit_fired", 8'(want.exit_fired), 8'(m_data.exit_fired));
                compare_field("entry_fired", 8'(want.entry_fired), 8'(m_data.entry_fired));
                compare_field("jumped", 8'(want.jumped), 8'(m_data.jumped));
                compare_field("state_index_now", 8'(want.state_index_now),
                              8'(m_data.state_index_now));
                compare_field("reported_state", 8'(want.reported_state),
                              8'(m_data.reported_state));
                compare_field("running", 8'(want.running), 8'(m_data.running));
                compare_field("fault", 8'(want.fault), 8'(m_data.fault));
                if (want.jumped) jumps_seen++;
                if (want.fault)  faults_seen++;
            end
        end
        if (hold_active) begin
            m_ready <= 1'b0;
        end else if (ready_gap > 0) begin
            ready_gap--;
            m_ready <= 1'b0;
        end else if (idle_on && $urandom_range(0, 5) == 0) begin
            ready_gap = $urandom_range(0, 10);
            m_ready <= 1'b0;
        end else begin
            m_ready <= 1'b1;
        end
    end

    // Long receiver hold-off: drop m_ready for a fixed stretch once asked
    initial begin : receiver_hold
        wait (hold_go);
        hold_active <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge aclk);
        hold_active <= 1'b0;
    end

    // Stop a hung run
    initial begin : watchdog
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge aclk);
            cycle_count++;
        end
        $display("%0t: run stopped after %0d cycles, %0d outcomes still pending",
                 $time, cycle_count, outcome_fifo.size());
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    // Nothing loaded yet: a stopped tick, a start, and a tick in an unloaded state
    task automatic test_idle_machine();
        offer_item(tick_item(FLAGS_W'($urandom)));
        offer_item(start_item());
        offer_item(tick_item('1));
    endtask

    // Load two states and walk every kind of sub-step outcome
    task automatic test_table_walk();
        // HOME: flag 0 gates the walk, flag 15 jumps to WORK, flag 7 hits the spare code
        offer_item(step_write(HOME, 2'd0, 4'd0,  ACT_NEXT,  ACT_END,  HOME));
        offer_item(step_write(HOME, 2'd1, 4'd15, ACT_JUMP,  ACT_NEXT, WORK));
        offer_item(step_write(HOME, 2'd2, 4'd7,  ACT_SPARE, ACT_NEXT, VOID));
        offer_item(step_write(HOME, 2'd3, 4'd8,  ACT_NEXT,  ACT_NEXT, HOME));
        offer_item(attr_write(HOME, 1'b1, 1'b1, 1'b1, 3'd7));
        // WORK: self jump, jump to an unloaded state, jump back home or spare end
        offer_item(step_write(WORK, 2'd0, 4'd3,  ACT_JUMP, ACT_NEXT,  WORK));
        offer_item(step_write(WORK, 2'd1, 4'd4,  ACT_JUMP, ACT_NEXT,  VOID));
        offer_item(step_write(WORK, 2'd2, 4'd5,  ACT_JUMP, ACT_SPARE, HOME));
        offer_item(step_write(WORK, 2'd3, 4'd15, ACT_END,  ACT_END,   HOME));
        offer_item(attr_write(WORK, 1'b0, 1'b0, 1'b1, 3'd0));
        // VOID gets one slot but stays unloaded
        offer_item(step_write(VOID, 2'd3, 4'd15, ACT_SPARE, ACT_SPARE, VOID));
        offer_item(start_item());
        offer_item(tick_item(16'h0000));   // end on the first slot
        offer_item(tick_item(16'h0001));   // run off the last slot
        offer_item(tick_item(16'h0081));   // spare code ends the walk
        offer_item(tick_item(16'h8001));   // jump to WORK, code zero keeps the report
        offer_item(tick_item(16'hFFFF));   // jump to itself
        offer_item(tick_item(16'h0000));   // spare code on the false side
        offer_item(tick_item(16'h0020));   // back home, publish its code
        offer_item(tick_item(16'h8001));
        offer_item(tick_item(16'h0010));   // jump to the unloaded state faults
        offer_item(tick_item(16'hFFFF));   // stopped: nothing moves
        offer_item(start_item());          // resume where the fault left off
    endtask

    // Hold the receiver off while ticks keep coming so the block stalls its input
    task automatic test_backpressure();
        idle_on = 1'b0;
        hold_go = 1'b1;
        offer_item(start_item());
        repeat (24) offer_item(tick_item(FLAGS_W'($urandom) & ~16'h0010));
        idle_on = 1'b1;
    endtask

    // Mostly ticks on a table that keeps changing, with idling in most stretches
    task automatic test_random_traffic();
        in_beat_t    it;
        int unsigned counted;
        counted = 0;
        while (counted < RANDOM_ITEMS) begin
            idle_on = (counted % 200) < 170;
            it = random_item();
            // ticks while stopped are ignored, so do not count them
            if (!(it.mode == MODE_TICK && !run_on)) counted++;
            offer_item(it);
        end
    endtask

    // Close with back-to-back traffic and no stalls on either side
    task automatic test_closing_burst();
        idle_on = 1'b0;
        repeat (CLOSING_ITEMS) offer_item(random_item());
    endtask

    initial begin
        aresetn = 1'b0;
        s_valid = 1'b0;
        s_data  = '0;
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;

        test_idle_machine();
        test_table_walk();
        test_backpressure();
        test_random_traffic();
        test_closing_burst();

        // Drop valid, drain the outcomes, then let the block settle
        s_valid <= 1'b0;
        while (outcome_fifo.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);

        $display("Covered %0d beats in and %0d checked out: %0d jumps, %0d faults,",
                 items_sent, beats_checked, jumps_seen, faults_seen);
        $display("with stalls on both sides and a long receiver hold-off.");
        if (mismatch_count == 0 && outcome_fifo.size() == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
